### src/fractional_knapsack_greedy_core_assert.svh
// Assertion macros shared by the knapsack core RTL
`ifndef FRACTIONAL_KNAPSACK_GREEDY_CORE_ASSERT_SVH
`define FRACTIONAL_KNAPSACK_GREEDY_CORE_ASSERT_SVH

// condition must hold on every clock out of reset
`define FKG_ASSERT_ALWAYS(label, clk, rstn, expr) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (expr)) \
        else $error("assertion failed");

// same-cycle implication
`define FKG_ASSERT_IMPLIES(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication
`define FKG_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

### src/fkg_pkg.sv
// Types, constants and helpers for the fractional knapsack core
package fkg_pkg;

    localparam int CAP_W    = 24;
    localparam int VAL_W    = 16;
    localparam int TOTAL_W  = 30;
    localparam int QUOT_W   = 24;
    localparam int DVD_W    = 40;
    localparam int DIV_STEPS = 40;
    localparam int DIV_CNT_W = 6;
    localparam logic [TOTAL_W-1:0] PROFIT_MAX = {TOTAL_W{1'b1}};

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_RD,
        ST_CMP,
        ST_WRITE,
        ST_FILL,
        ST_FRD,
        ST_FGET,
        ST_FMUL,
        ST_FDIV,
        ST_OUT
    } state_t;

    function automatic logic [TOTAL_W-1:0] sat_add(input logic [TOTAL_W-1:0] a,
                                                   input logic [QUOT_W-1:0] b);
        logic [TOTAL_W:0] s;
        s = {1'b0, a} + (TOTAL_W + 1)'(b);
        return (s > {1'b0, PROFIT_MAX}) ? PROFIT_MAX : s[TOTAL_W-1:0];
    endfunction

endpackage

### src/fractional_knapsack_greedy_core.sv
// Fractional knapsack greedy core: insertion sort by ratio, then greedy fill
// Usage:
//   cfg_* writes the 24-bit capacity; cfg_ready is always high. Write it only
//   while the core is idle.
//   s_* takes one item (profit, weight, final flag). s_ready is high only when
//   the sequencer is idle. After the accepting edge insertion reads and shifts
//   stored entries one at a time, through the single store port and the one
//   ratio comparator.
//   An item with s_final_item high starts the fill. The fill emits one item
//   on m_* per object taken, in descending ratio order; a whole object waits
//   for the receiver, the fractional one also for the 40-step serial divider.
//   m_last_result marks the final result.
//   Items arriving with the store full are dropped and m_overflowed is set
//   on every result of that set.
//   When m_ready is low the result holds in the output register and the
//   sequencer waits. Reset (aresetn low, synchronous) empties the store and
//   clears capacity to zero.
`include "fractional_knapsack_greedy_core_assert.svh"

module fractional_knapsack_greedy_core #(
    parameter int MAX_ITEMS = 32
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [23:0] cfg_data,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [15:0] s_item_profit,
    input  logic [15:0] s_item_weight,
    input  logic        s_final_item,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [15:0] m_chosen_profit,
    output logic [15:0] m_chosen_weight,
    output logic [15:0] m_taken_weight,
    output logic        m_is_partial,
    output logic [29:0] m_running_profit,
    output logic        m_overflowed,
    output logic        m_last_result
);

    localparam int ADDR_W = $clog2(MAX_ITEMS);
    localparam int CNT_W  = $clog2(MAX_ITEMS + 1);

    fkg_pkg::state_t state_reg, state_next;

    logic [15:0]       p_reg, w_reg;
    logic              fin_reg;
    logic [ADDR_W-1:0] pos_reg, k_reg;
    logic [CNT_W-1:0]  count_reg;
    logic              drop_reg;
    logic [23:0]       cap_reg, rem_reg;
    logic [29:0]       total_reg;
    logic [31:0]       prod_reg;

    logic [15:0] out_profit_reg, out_weight_reg, out_taken_reg;
    logic        out_partial_reg, out_drop_reg, out_last_reg, m_valid_reg;

    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr, rd_addr;
    logic [31:0]       wr_data, rd_data;
    logic              div_start, div_done;
    logic [23:0]       div_quot;

    logic [31:0] lhs, rhs;
    logic        shift_go, store_full, partial;
    logic [15:0] rd_p, rd_w;

    assign rd_p       = rd_data[31:16];
    assign rd_w       = rd_data[15:0];
    assign lhs        = rd_p * w_reg;
    assign rhs        = p_reg * rd_w;
    assign shift_go   = lhs < rhs;
    assign store_full = count_reg == CNT_W'(MAX_ITEMS);
    assign partial    = {8'd0, rd_w} > rem_reg;

    fkg_store #(.DEPTH(MAX_ITEMS), .ADDR_W(ADDR_W)) u_store (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    fkg_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend ({prod_reg, 8'd0}),
        .divisor  (out_weight_reg),
        .done     (div_done),
        .quotient (div_quot)
    );

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            fkg_pkg::ST_IDLE: begin
                if (s_valid) begin
                    if (store_full) begin
                        state_next = s_final_item ? fkg_pkg::ST_FILL : fkg_pkg::ST_IDLE;
                    end else if (count_reg == '0) begin
                        state_next = fkg_pkg::ST_WRITE;
                    end else begin
                        state_next = fkg_pkg::ST_RD;
                    end
                end
            end
            fkg_pkg::ST_RD:    state_next = fkg_pkg::ST_CMP;
            fkg_pkg::ST_CMP: begin
                if (!shift_go || pos_reg == ADDR_W'(1)) begin
                    state_next = fkg_pkg::ST_WRITE;
                end
            end
            fkg_pkg::ST_WRITE: state_next = fin_reg ? fkg_pkg::ST_FILL : fkg_pkg::ST_IDLE;
            fkg_pkg::ST_FILL:  state_next = (count_reg == '0) ? fkg_pkg::ST_IDLE
                                                             : fkg_pkg::ST_FRD;
            fkg_pkg::ST_FRD:   state_next = fkg_pkg::ST_FGET;
            fkg_pkg::ST_FGET:  state_next = partial ? fkg_pkg::ST_FMUL : fkg_pkg::ST_OUT;
            fkg_pkg::ST_FMUL:  state_next = fkg_pkg::ST_FDIV;
            fkg_pkg::ST_FDIV: begin
                if (div_done) begin
                    state_next = fkg_pkg::ST_OUT;
                end
            end
            fkg_pkg::ST_OUT: begin
                if (m_ready) begin
                    state_next = out_last_reg ? fkg_pkg::ST_IDLE : fkg_pkg::ST_FRD;
                end
            end
            default: state_next = fkg_pkg::ST_IDLE;
        endcase
    end

    // store and divider controls
    always_comb begin
        wr_en     = 1'b0;
        wr_addr   = pos_reg;
        wr_data   = {p_reg, w_reg};
        rd_addr   = k_reg;
        div_start = 1'b0;
        unique case (state_reg)
            fkg_pkg::ST_RD: rd_addr = pos_reg - 1'b1;
            fkg_pkg::ST_CMP: begin
                // move the entry up one slot and fetch the one below it
                if (shift_go) begin
                    wr_en   = 1'b1;
                    wr_data = rd_data;
                end
                rd_addr = pos_reg - ADDR_W'(2);
            end
            fkg_pkg::ST_WRITE: wr_en = 1'b1;
            fkg_pkg::ST_FMUL:  div_start = 1'b1;
            default: ;
        endcase
    end

    assign s_ready   = state_reg == fkg_pkg::ST_IDLE;
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= fkg_pkg::ST_IDLE;
            count_reg   <= '0;
            drop_reg    <= 1'b0;
            cap_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cfg_valid) begin
                cap_reg <= cfg_data;
            end
            if (state_reg == fkg_pkg::ST_IDLE && s_valid && store_full) begin
                drop_reg <= 1'b1;
            end
            if (state_reg == fkg_pkg::ST_WRITE) begin
                count_reg <= count_reg + 1'b1;
            end
            if (state_reg == fkg_pkg::ST_FILL && count_reg == '0) begin
                drop_reg <= 1'b0;
            end
            if (state_reg == fkg_pkg::ST_FGET && !partial) begin
                m_valid_reg <= 1'b1;
            end
            if (state_reg == fkg_pkg::ST_FDIV && div_done) begin
                m_valid_reg <= 1'b1;
            end
            if (state_reg == fkg_pkg::ST_OUT && m_ready) begin
                m_valid_reg <= 1'b0;
                if (out_last_reg) begin
                    count_reg <= '0;
                    drop_reg  <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        unique case (state_reg)
            fkg_pkg::ST_IDLE: begin
                if (s_valid) begin
                    p_reg   <= s_item_profit;
                    w_reg   <= s_item_weight;
                    fin_reg <= s_final_item;
                    pos_reg <= count_reg[ADDR_W-1:0];
                end
            end
            fkg_pkg::ST_CMP: begin
                if (shift_go) begin
                    pos_reg <= pos_reg - 1'b1;
                end
            end
            fkg_pkg::ST_FILL: begin
                k_reg     <= '0;
                rem_reg   <= cap_reg;
                total_reg <= '0;
            end
            fkg_pkg::ST_FGET: begin
                out_profit_reg <= rd_p;
                out_weight_reg <= rd_w;
                out_drop_reg   <= drop_reg;
                out_partial_reg <= partial;
                if (partial) begin
                    out_taken_reg <= rem_reg[15:0];
                    out_last_reg  <= 1'b1;
                    prod_reg      <= rem_reg[15:0] * rd_p;
                    rem_reg       <= '0;
                end else begin
                    out_taken_reg <= rd_w;
                    out_last_reg  <= (CNT_W'(k_reg) + 1'b1) == count_reg;
                    rem_reg       <= rem_reg - {8'd0, rd_w};
                    total_reg     <= fkg_pkg::sat_add(total_reg, {rd_p, 8'd0});
                end
            end
            fkg_pkg::ST_FDIV: begin
                if (div_done) begin
                    total_reg <= fkg_pkg::sat_add(total_reg, div_quot);
                end
            end
            fkg_pkg::ST_OUT: begin
                if (m_ready && !out_last_reg) begin
                    k_reg <= k_reg + 1'b1;
                end
            end
            default: ;
        endcase
    end

    assign m_valid          = m_valid_reg;
    assign m_chosen_profit  = out_profit_reg;
    assign m_chosen_weight  = out_weight_reg;
    assign m_taken_weight   = out_taken_reg;
    assign m_is_partial     = out_partial_reg;
    assign m_running_profit = total_reg;
    assign m_overflowed     = out_drop_reg;
    assign m_last_result    = out_last_reg;

    `FKG_ASSERT_ALWAYS(a_count_bound, aclk, aresetn, count_reg <= CNT_W'(MAX_ITEMS))
    `FKG_ASSERT_IMPLIES(a_ready_no_result, aclk, aresetn, s_ready, !m_valid_reg)
    `FKG_ASSERT_NEXT(a_set_cleared, aclk, aresetn, m_valid && m_ready && m_last_result,
                     count_reg == '0 && !drop_reg)
    `FKG_ASSERT_IMPLIES(a_div_in_state, aclk, aresetn, div_done,
                        state_reg == fkg_pkg::ST_FDIV)

endmodule

### src/fkg_store.sv
// Sorted item store: one write port, one registered read port
module fkg_store #(
    parameter int DEPTH  = 32,
    parameter int ADDR_W = 5
) (
    input  logic              aclk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [31:0]       wr_data,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [31:0]       rd_data
);

    logic [31:0] mem [DEPTH];
    logic [31:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

### src/fkg_div.sv
// Bit-serial restoring divider for the fractional share
module fkg_div (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        start,
    input  logic [fkg_pkg::DVD_W-1:0]   dividend,
    input  logic [fkg_pkg::VAL_W-1:0]   divisor,
    output logic                        done,
    output logic [fkg_pkg::QUOT_W-1:0]  quotient
);

    logic                          busy_reg;
    logic                          done_reg;
    logic [fkg_pkg::DIV_CNT_W-1:0] cnt_reg;
    logic [fkg_pkg::DVD_W-1:0]     dvd_reg;
    logic [fkg_pkg::VAL_W-1:0]     rem_reg;
    logic [fkg_pkg::VAL_W:0]       trial;
    logic                          fits;

    assign trial = {rem_reg, dvd_reg[fkg_pkg::DVD_W-1]};
    assign fits  = trial >= {1'b0, divisor};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
            end else if (busy_reg &&
                         cnt_reg == fkg_pkg::DIV_CNT_W'(fkg_pkg::DIV_STEPS - 1)) begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            dvd_reg <= dividend;
            rem_reg <= '0;
            cnt_reg <= '0;
        end else if (busy_reg) begin
            rem_reg <= fits ? fkg_pkg::VAL_W'(trial - {1'b0, divisor})
                            : trial[fkg_pkg::VAL_W-1:0];
            dvd_reg <= {dvd_reg[fkg_pkg::DVD_W-2:0], fits};
            cnt_reg <= cnt_reg + 1'b1;
        end
    end

    assign done     = done_reg;
    assign quotient = dvd_reg[fkg_pkg::QUOT_W-1:0];

endmodule

### verif/tb.sv
// Self-checking testbench for the fractional knapsack greedy core
`timescale 1ns / 100ps

module tb;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [23:0] cfg_data = '0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [15:0] s_item_profit = '0;
    logic [15:0] s_item_weight = 16'd1;
    logic        s_final_item = 1'b0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [15:0] m_chosen_profit;
    logic [15:0] m_chosen_weight;
    logic [15:0] m_taken_weight;
    logic        m_is_partial;
    logic [29:0] m_running_profit;
    logic        m_overflowed;
    logic        m_last_result;

    localparam int STORE_DEPTH = 32;
    localparam int STALL_LIMIT = 20000;

    typedef struct packed {
        logic [15:0] profit;
        logic [15:0] weight;
        logic        final_item;
    } obj_t;

    typedef struct packed {
        logic [15:0] profit;
        logic [15:0] weight;
        logic [15:0] taken;
        logic        partial;
        logic [29:0] total;
        logic        dropped;
        logic        last;
    } pick_t;

    fractional_knapsack_greedy_core u_top (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_data        (cfg_data),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_item_profit   (s_item_profit),
        .s_item_weight   (s_item_weight),
        .s_final_item    (s_final_item),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_chosen_profit (m_chosen_profit),
        .m_chosen_weight (m_chosen_weight),
        .m_taken_weight  (m_taken_weight),
        .m_is_partial    (m_is_partial),
        .m_running_profit(m_running_profit),
        .m_overflowed    (m_overflowed),
        .m_last_result   (m_last_result)
    );

    always #5 aclk = ~aclk;

    // predictor state
    logic [15:0] sorted_p [STORE_DEPTH];
    logic [15:0] sorted_w [STORE_DEPTH];
    int          n_stored;
    logic        dropped_any;
    logic [23:0] knap_cap;

    obj_t  pending_q [$];
    pick_t picks_q [$];
    int    errors;
    int    n_items;
    int    n_picks;
    int    n_partial;
    int    n_overflow_sets;
    bit    send_idle_ok;
    bit    recv_idle_ok;
    int    hold_cycles;
    int    send_gap;
    int    recv_gap;
    int    quiet_cycles;

    function automatic void store_object(input logic [15:0] p, input logic [15:0] w);
        int pos;
        pos = n_stored;
        if (n_stored >= STORE_DEPTH) begin
            dropped_any = 1'b1;
            return;
        end
        while (pos > 0) begin
            if (!(48'(sorted_p[pos-1]) * w < 48'(p) * sorted_w[pos-1]))
                break;
            sorted_p[pos] = sorted_p[pos-1];
            sorted_w[pos] = sorted_w[pos-1];
            pos--;
        end
        sorted_p[pos] = p;
        sorted_w[pos] = w;
        n_stored++;
    endfunction

    function automatic void predict_fill(input obj_t o);
        logic [63:0] remain;
        logic [63:0] sum;
        logic [63:0] add;
        pick_t r;
        int first;
        store_object(o.profit, o.weight);
        if (!o.final_item)
            return;
        remain = knap_cap;
        sum = 0;
        first = picks_q.size();
        if (dropped_any)
            n_overflow_sets++;
        for (int k = 0; k < n_stored; k++) begin
            r.profit = sorted_p[k];
            r.weight = sorted_w[k];
            r.partial = 64'(sorted_w[k]) > remain;
            if (r.partial) begin
                r.taken = remain[15:0];
                add = ((remain * sorted_p[k]) << 8) / sorted_w[k];
                remain = 0;
                n_partial++;
            end else begin
                r.taken = sorted_w[k];
                add = 64'(sorted_p[k]) << 8;
                remain = remain - sorted_w[k];
            end
            sum = sum + add;
            if (sum > 64'h3FFF_FFFF)
                sum = 64'h3FFF_FFFF;
            r.total = sum[29:0];
            r.dropped = dropped_any;
            r.last = 1'b0;
            picks_q.push_back(r);
            if (r.partial)
                break;
        end
        if (picks_q.size() > first)
            picks_q[picks_q.size()-1].last = 1'b1;
        n_stored = 0;
        dropped_any = 1'b0;
    endfunction

    // sender
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready) begin
                predict_fill('{s_item_profit, s_item_weight, s_final_item});
                n_items++;
            end
            if (!(s_valid && !s_ready)) begin
                if (send_gap > 0) begin
                    send_gap <= send_gap - 1;
                    s_valid <= 1'b0;
                end else if (pending_q.size() > 0 && send_idle_ok &&
                             $urandom_range(0, 5) == 0) begin
                    send_gap <= $urandom_range(0, 2);
                    s_valid <= 1'b0;
                end else if (pending_q.size() > 0) begin
                    s_valid <= 1'b1;
                    s_item_profit <= pending_q[0].profit;
                    s_item_weight <= pending_q[0].weight;
                    s_final_item <= pending_q[0].final_item;
                    void'(pending_q.pop_front());
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // receiver and checker
    always @(posedge aclk) begin
        pick_t want;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                n_picks++;
                if (picks_q.size() == 0) begin
                    $display("%0t: unexpected result, actual %h", $time,
                             {m_chosen_profit, m_chosen_weight, m_taken_weight});
                    errors++;
                end else begin
                    want = picks_q.pop_front();
                    if (want != {m_chosen_profit, m_chosen_weight, m_taken_weight,
                                 m_is_partial, m_running_profit, m_overflowed,
                                 m_last_result}) begin
                        $display("%0t: result mismatch", $time);
                        $display("  profit %0d/%0d weight %0d/%0d taken %0d/%0d",
                                 want.profit, m_chosen_profit, want.weight,
                                 m_chosen_weight, want.taken, m_taken_weight);
                        $display("  partial %0b/%0b total %0d/%0d ovf %0b/%0b last %0b/%0b",
                                 want.partial, m_is_partial, want.total,
                                 m_running_profit, want.dropped, m_overflowed,
                                 want.last, m_last_result);
                        errors++;
                    end
                end
            end
            if (hold_cycles > 0) begin
                hold_cycles <= hold_cycles - 1;
                m_ready <= 1'b0;
            end else if (recv_gap > 0) begin
                recv_gap <= recv_gap - 1;
                m_ready <= 1'b0;
            end else if (recv_idle_ok && $urandom_range(0, 4) == 0) begin
                recv_gap <= $urandom_range(0, 2);
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // watchdog
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready) ||
            hold_cycles > 0) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("fractional_knapsack_greedy_core: mismatch");
                $finish;
            end
        end
    end

    task automatic write_capacity(input logic [23:0] c);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_data <= c;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        knap_cap = c;
    endtask

    task automatic drain();
        while (pending_q.size() > 0 || s_valid || picks_q.size() > 0)
            @(posedge aclk);
        repeat (60) @(posedge aclk);
    endtask

    function automatic obj_t rand_obj(input bit fin);
        obj_t o;
        case ($urandom_range(0, 5))
            0: o.profit = 16'hFFFF;
            1: o.profit = 16'd0;
            default: o.profit = $urandom_range(0, 65535);
        endcase
        case ($urandom_range(0, 5))
            0: o.weight = 16'hFFFF;
            1: o.weight = 16'd1;
            2: o.weight = $urandom_range(1, 64);
            default: o.weight = $urandom_range(1, 65535);
        endcase
        o.final_item = fin;
        return o;
    endfunction

    task automatic queue_set(input int len);
        for (int i = 0; i < len; i++)
            pending_q.push_back(rand_obj(i == len - 1));
    endtask

    initial begin
        n_stored = 0;
        dropped_any = 1'b0;
        knap_cap = '0;
        errors = 0;
        n_items = 0;
        n_picks = 0;
        n_partial = 0;
        n_overflow_sets = 0;
        hold_cycles = 0;
        send_gap = 0;
        recv_gap = 0;
        quiet_cycles = 0;
        send_idle_ok = 1'b1;
        recv_idle_ok = 1'b1;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        // zero capacity: first object comes out partial with nothing taken
        pending_q.push_back('{16'd10, 16'd5, 1'b0});
        pending_q.push_back('{16'd7, 16'd2, 1'b1});
        drain();

        write_capacity(24'd100);
        // equal ratios keep arrival order; exact fill then zero-taken partial
        pending_q.push_back('{16'd20, 16'd10, 1'b0});
        pending_q.push_back('{16'd40, 16'd20, 1'b0});
        pending_q.push_back('{16'd10, 16'd5, 1'b0});
        pending_q.push_back('{16'd130, 16'd65, 1'b0});
        pending_q.push_back('{16'd1, 16'd3, 1'b1});
        pending_q.push_back('{16'hFFFF, 16'hFFFF, 1'b1});
        pending_q.push_back('{16'd0, 16'd1, 1'b0});
        pending_q.push_back('{16'd0, 16'd1, 1'b1});
        drain();

        // everything fits
        write_capacity(24'hFFFFFF);
        pending_q.push_back('{16'hFFFF, 16'h0001, 1'b0});
        pending_q.push_back('{16'h0001, 16'hFFFF, 1'b0});
        pending_q.push_back('{16'h8000, 16'h8000, 1'b1});
        drain();

        // store overflow, with the dropped object being the final one
        write_capacity(24'd300000);
        queue_set(STORE_DEPTH + 2);
        drain();

        // long receiver hold-off while the sender keeps offering
        recv_idle_ok = 1'b0;
        hold_cycles = 400;
        queue_set(6);
        queue_set(5);
        drain();
        recv_idle_ok = 1'b1;

        for (int ph = 0; ph < 6; ph++) begin
            case (ph)
                0: write_capacity(24'd1);
                1: write_capacity($urandom_range(1000, 100000));
                2: write_capacity(24'd0);
                3: write_capacity($urandom_range(100000, 16777215));
                4: write_capacity(24'hFFFFFF);
                default: write_capacity($urandom_range(10000, 200000));
            endcase
            if (ph == 5) begin
                send_idle_ok = 1'b0;
                recv_idle_ok = 1'b0;
            end
            for (int s = 0; s < 7; s++) begin
                if ($urandom_range(0, 9) == 0)
                    queue_set(STORE_DEPTH + $urandom_range(1, 3));
                else
                    queue_set($urandom_range(1, 8));
            end
            drain();
        end

        $display("run: %0d items in, %0d results out, %0d partial picks", n_items,
                 n_picks, n_partial);
        $display("run: %0d sets overflowed the store, capacities from 0 to full scale",
                 n_overflow_sets);
        if (errors == 0)
            $display("fractional_knapsack_greedy_core: match");
        else
            $display("fractional_knapsack_greedy_core: mismatch");
        $finish;
    end

    final begin
    end

endmodule
